### rtl/core/ntc_pkg.sv
// ----------------------------------------------------------------------------
// ntc_pkg
// Widths, register codes and fixed-point constants of the NTC thermistor
// temperature converter.
// ----------------------------------------------------------------------------
package ntc_pkg;

  // field and register widths
  localparam int CODE_W = 16;
  localparam int VREF_W = 13;
  localparam int BETA_W = 14;
  localparam int TEMP_W = 11;
  localparam int CFG_W  = 14;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_VREF = 1'b0,
    REG_BETA = 1'b1
  } cfg_reg_t;

  localparam logic [VREF_W-1:0] VREF_RST = 13'd2500;
  localparam logic [BETA_W-1:0] BETA_RST = 14'd3477;

  // divider supply in mV and R_nominal * supply
  localparam logic [13:0] SUPPLY_MV = 14'd5000;
  localparam logic [25:0] DIV1_NUM  = 26'd50000000;

  // ln(2) in Q30
  localparam logic [29:0] LN2_Q30 = 30'd744261118;

  // 1/298 K in Q39, rounded
  localparam logic [34:0] INV_T0 = 35'(((64'd1 << 39) + 64'd149) / 64'd298);

  // 273 K and 100 degrees in Q24
  localparam logic signed [34:0] KELVIN_Q24 = 35'sd4580179968;
  localparam logic signed [34:0] TLIM_Q24   = 35'sd1677721600;

  localparam logic [TEMP_W-1:0] TEMP_FLOOR = 11'h418;  // -1000

  // log2 in Q30 by repeated squaring, evaluated at elaboration only
  function automatic longint unsigned log2_q30_fn(input longint unsigned x);
    longint unsigned res;
    longint unsigned m;
    int n;
    n = 0;
    for (int i = 0; i < 62; i++) begin
      if ((x >> (i + 1)) != 0) n = i + 1;
    end
    m   = x << (30 - n);
    res = longint'(n) << 30;
    for (int i = 29; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= (64'd2 << 30)) begin
        m   = m >> 1;
        res = res | (64'd1 << i);
      end
    end
    return res;
  endfunction

  // log2(10000) in Q30
  localparam logic [34:0] L2_NOM = 35'(log2_q30_fn(64'd10000));

endpackage

### rtl/core/ntc_thermistor_temperature_top.sv
// Throughput: one request per cycle unless the output stalls; each long division
// and the log2 squaring chain is unrolled into register stages, one or two steps each.
// A stalled output backs up stage by stage; bubbles are squeezed out.
// Reset clears all valid bits and loads vref_mv = 2500, beta_kelvin = 3477.
// ----------------------------------------------------------------------------
// ntc_thermistor_temperature_top
// ADC code to temperature in tenths of a degree via the beta equation.
// ----------------------------------------------------------------------------
module ntc_thermistor_temperature_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] adc_code
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [10:0] temp_decidegree, [15:11] zero
  input  logic        cfg_wr_en,
  input  logic [0:0]  cfg_addr,
  input  logic [13:0] cfg_wdata
);

  // stage map
  localparam int ST_IN   = 0;
  localparam int ST_DEN  = 1;
  localparam int ST_D1   = 2;
  localparam int D1_N    = 13;
  localparam int ST_NORM = ST_D1 + D1_N;
  localparam int ST_LOG  = ST_NORM + 1;
  localparam int LG_N    = 30;
  localparam int ST_SUB  = ST_LOG + LG_N;
  localparam int ST_MUL  = ST_SUB + 1;
  localparam int ST_LN   = ST_MUL + 1;
  localparam int ST_D2   = ST_LN + 1;
  localparam int D2_N    = 22;
  localparam int ST_INV  = ST_D2 + D2_N;
  localparam int ST_D3   = ST_INV + 1;
  localparam int D3_N    = 17;
  localparam int ST_OUT  = ST_D3 + D3_N;
  localparam int NS      = ST_OUT + 1;

  // configuration registers
  logic [ntc_pkg::VREF_W-1:0] vref_mv;
  logic [ntc_pkg::BETA_W-1:0] beta_kelvin;
  logic [ntc_pkg::BETA_W-1:0] beta_div;

  always_ff @(posedge clk) begin
    if (rst) begin
      vref_mv     <= ntc_pkg::VREF_RST;
      beta_kelvin <= ntc_pkg::BETA_RST;
    end else if (cfg_wr_en) begin
      unique case (ntc_pkg::cfg_reg_t'(cfg_addr))
        ntc_pkg::REG_VREF: vref_mv     <= cfg_wdata[ntc_pkg::VREF_W-1:0];
        ntc_pkg::REG_BETA: beta_kelvin <= cfg_wdata;
        default:           vref_mv     <= vref_mv;
      endcase
    end
  end

  // zero beta is taken as one
  assign beta_div = (beta_kelvin == '0) ? 14'd1 : beta_kelvin;

  // valid / ready chain
  logic vld [NS];
  logic rdy [NS+1];
  logic sat [ST_DEN:ST_OUT-1];

  assign rdy[NS]       = m_axis_tready;
  assign s_axis_tready = rdy[0];

  for (genvar i = 0; i < NS; i++) begin : g_ctl
    assign rdy[i] = !vld[i] || rdy[i+1];
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (rdy[i]) begin
        vld[i] <= (i == 0) ? s_axis_tvalid : vld[(i == 0) ? 0 : i-1];
      end
    end
  end

  for (genvar i = ST_DEN + 1; i < ST_OUT; i++) begin : g_sat
    always_ff @(posedge clk) begin
      if (rdy[i]) sat[i] <= sat[i-1];
    end
  end

  // stage 0: clamp code to 0..vref, scale by vref
  logic signed [15:0] code_s;
  logic [12:0]        code_c;
  logic [25:0]        prod0;

  always_comb begin
    code_s = signed'(s_axis_tdata);
    if (code_s[15])                              code_c = '0;
    else if (code_s[14:0] >= {2'b00, vref_mv})   code_c = vref_mv;
    else                                         code_c = code_s[12:0];
  end

  always_ff @(posedge clk) begin
    if (rdy[ST_IN]) prod0 <= 26'(vref_mv) * 26'(code_c);
  end

  // stage 1: millivolts and divider headroom
  logic [13:0] mv;
  logic [12:0] den1;

  assign mv = prod0[25:12];

  always_ff @(posedge clk) begin
    if (rdy[ST_DEN]) begin
      sat[ST_DEN] <= (mv >= ntc_pkg::SUPPLY_MV);
      den1        <= 13'(ntc_pkg::SUPPLY_MV - mv);
    end
  end

  // resistance = 50e6 / den, two quotient bits per stage
  logic [12:0] d1_rem [D1_N];
  logic [25:0] d1_q   [D1_N];
  logic [12:0] d1_den [D1_N];

  for (genvar k = 0; k < D1_N; k++) begin : g_d1
    logic [12:0] rem_i, den_i, rem_a, rem_b;
    logic [25:0] q_i, q_a, q_b;
    logic [13:0] t_a, t_b;
    logic        ge_a, ge_b;

    if (k == 0) begin : g_src
      assign rem_i = '0;
      assign q_i   = '0;
      assign den_i = den1;
    end else begin : g_src
      assign rem_i = d1_rem[k-1];
      assign q_i   = d1_q[k-1];
      assign den_i = d1_den[k-1];
    end

    always_comb begin
      t_a   = {rem_i, ntc_pkg::DIV1_NUM[25-2*k]};
      ge_a  = t_a >= {1'b0, den_i};
      rem_a = ge_a ? 13'(t_a - {1'b0, den_i}) : t_a[12:0];
      q_a   = {q_i[24:0], ge_a};
      t_b   = {rem_a, ntc_pkg::DIV1_NUM[24-2*k]};
      ge_b  = t_b >= {1'b0, den_i};
      rem_b = ge_b ? 13'(t_b - {1'b0, den_i}) : t_b[12:0];
      q_b   = {q_a[24:0], ge_b};
    end

    always_ff @(posedge clk) begin
      if (rdy[ST_D1+k]) begin
        d1_rem[k] <= rem_b;
        d1_q[k]   <= q_b;
        d1_den[k] <= den_i;
      end
    end
  end

  // normalize resistance to [1,2) in Q30, integer part of log2
  logic [25:0] r_val;
  logic [4:0]  r_msb;
  logic [30:0] nm_m;
  logic [34:0] nm_res;

  assign r_val = d1_q[D1_N-1];

  always_comb begin
    r_msb = '0;
    for (int b = 0; b < 26; b++) begin
      if (r_val[b]) r_msb = 5'(b);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[ST_NORM]) begin
      nm_m   <= 31'(r_val) << (5'd30 - r_msb);
      nm_res <= {r_msb, 30'b0};
    end
  end

  // fraction of log2: one squaring per stage
  logic [30:0] lg_m   [LG_N];
  logic [34:0] lg_res [LG_N];

  for (genvar j = 0; j < LG_N; j++) begin : g_lg
    logic [30:0] m_i, m_o;
    logic [34:0] res_i, res_o;
    logic [61:0] sq;
    logic [31:0] m2;

    if (j == 0) begin : g_src
      assign m_i   = nm_m;
      assign res_i = nm_res;
    end else begin : g_src
      assign m_i   = lg_m[j-1];
      assign res_i = lg_res[j-1];
    end

    always_comb begin
      sq = 62'(m_i) * 62'(m_i);
      m2 = sq[61:30];
      if (m2[31]) begin
        m_o   = m2[31:1];
        res_o = res_i | (35'd1 << (29 - j));
      end else begin
        m_o   = m2[30:0];
        res_o = res_i;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[ST_LOG+j]) begin
        lg_m[j]   <= m_o;
        lg_res[j] <= res_o;
      end
    end
  end

  // log2(R/10000), then ln by ln2 in two partial products
  logic [33:0] l2;
  logic [61:0] plo;
  logic [31:0] phi;
  logic [63:0] ln_sum;
  logic [33:0] ln_q30;

  always_ff @(posedge clk) begin
    if (rdy[ST_SUB]) l2 <= 34'(lg_res[LG_N-1] - ntc_pkg::L2_NOM);
  end

  always_ff @(posedge clk) begin
    if (rdy[ST_MUL]) begin
      plo <= 62'(l2[31:0]) * 62'(ntc_pkg::LN2_Q30);
      phi <= 32'(l2[33:32]) * 32'(ntc_pkg::LN2_Q30);
    end
  end

  assign ln_sum = 64'(plo) + {phi, 32'b0};

  always_ff @(posedge clk) begin
    if (rdy[ST_LN]) ln_q30 <= ln_sum[63:30];
  end

  // (ln << 9) / beta, two quotient bits per stage, one in the last
  logic [13:0] d2_rem [D2_N];
  logic [42:0] d2_q   [D2_N];
  logic [42:0] d2_num [D2_N];

  for (genvar k = 0; k < D2_N; k++) begin : g_d2
    logic [13:0] rem_i, rem_a, rem_o;
    logic [42:0] q_i, q_a, q_o, num_i;
    logic [14:0] t_a;
    logic        ge_a;

    if (k == 0) begin : g_src
      assign rem_i = '0;
      assign q_i   = '0;
      assign num_i = {ln_q30, 9'b0};
    end else begin : g_src
      assign rem_i = d2_rem[k-1];
      assign q_i   = d2_q[k-1];
      assign num_i = d2_num[k-1];
    end

    always_comb begin
      t_a   = {rem_i, num_i[42-2*k]};
      ge_a  = t_a >= {1'b0, beta_div};
      rem_a = ge_a ? 14'(t_a - {1'b0, beta_div}) : t_a[13:0];
      q_a   = {q_i[41:0], ge_a};
    end

    if (k < D2_N - 1) begin : g_two
      logic [14:0] t_b;
      logic        ge_b;
      always_comb begin
        t_b   = {rem_a, num_i[41-2*k]};
        ge_b  = t_b >= {1'b0, beta_div};
        rem_o = ge_b ? 14'(t_b - {1'b0, beta_div}) : t_b[13:0];
        q_o   = {q_a[41:0], ge_b};
      end
    end else begin : g_one
      assign rem_o = rem_a;
      assign q_o   = q_a;
    end

    always_ff @(posedge clk) begin
      if (rdy[ST_D2+k]) begin
        d2_rem[k] <= rem_o;
        d2_q[k]   <= q_o;
        d2_num[k] <= num_i;
      end
    end
  end

  // 1/T in Q39; a sum past 35 bits means T far below -100 C, so pin it
  logic [43:0] inv_sum;
  logic [34:0] inv;

  assign inv_sum = 44'(d2_q[D2_N-1]) + 44'(ntc_pkg::INV_T0);

  always_ff @(posedge clk) begin
    if (rdy[ST_INV]) inv <= (inv_sum[43:35] != '0) ? '1 : inv_sum[34:0];
  end

  // T = 2^63 / inv, Q24 kelvin; upper quotient bits are known zero
  logic [34:0] d3_rem [D3_N];
  logic [32:0] d3_q   [D3_N];
  logic [34:0] d3_inv [D3_N];

  for (genvar k = 0; k < D3_N; k++) begin : g_d3
    logic [34:0] rem_i, rem_a, rem_o, inv_i;
    logic [32:0] q_i, q_a, q_o;
    logic [35:0] t_a;
    logic        ge_a;

    if (k == 0) begin : g_src
      assign rem_i = 35'd1 << 30;
      assign q_i   = '0;
      assign inv_i = inv;
    end else begin : g_src
      assign rem_i = d3_rem[k-1];
      assign q_i   = d3_q[k-1];
      assign inv_i = d3_inv[k-1];
    end

    always_comb begin
      t_a   = {rem_i, 1'b0};
      ge_a  = t_a >= {1'b0, inv_i};
      rem_a = ge_a ? 35'(t_a - {1'b0, inv_i}) : t_a[34:0];
      q_a   = {q_i[31:0], ge_a};
    end

    if (k < D3_N - 1) begin : g_two
      logic [35:0] t_b;
      logic        ge_b;
      always_comb begin
        t_b   = {rem_a, 1'b0};
        ge_b  = t_b >= {1'b0, inv_i};
        rem_o = ge_b ? 35'(t_b - {1'b0, inv_i}) : t_b[34:0];
        q_o   = {q_a[31:0], ge_b};
      end
    end else begin : g_one
      assign rem_o = rem_a;
      assign q_o   = q_a;
    end

    always_ff @(posedge clk) begin
      if (rdy[ST_D3+k]) begin
        d3_rem[k] <= rem_o;
        d3_q[k]   <= q_o;
        d3_inv[k] <= inv_i;
      end
    end
  end

  // Celsius, saturate, tenths truncated toward zero
  logic signed [34:0] tc;
  logic signed [34:0] tc_s;
  logic signed [38:0] dec;
  logic [38:0]        dec_mag;
  logic [10:0]        dec_q;
  logic [10:0]        temp_next;
  logic [10:0]        temp;

  always_comb begin
    tc = signed'({2'b00, d3_q[D3_N-1]}) - ntc_pkg::KELVIN_Q24;
    if (tc >= ntc_pkg::TLIM_Q24)       tc_s = ntc_pkg::TLIM_Q24;
    else if (tc <= -ntc_pkg::TLIM_Q24) tc_s = -ntc_pkg::TLIM_Q24;
    else                               tc_s = tc;
    dec     = 39'(tc_s) * 39'sd10;
    dec_mag = dec[38] ? 39'(-dec) : 39'(dec);
    dec_q   = dec_mag[34:24];
    if (sat[ST_OUT-1])  temp_next = ntc_pkg::TEMP_FLOOR;
    else if (dec[38])   temp_next = 11'(-dec_q);
    else                temp_next = dec_q;
  end

  always_ff @(posedge clk) begin
    if (rdy[ST_OUT]) temp <= temp_next;
  end

  assign m_axis_tvalid = vld[ST_OUT];
  assign m_axis_tdata  = {5'b0, temp};

  // checks
  a_empty_out_ready: assert property (@(posedge clk) disable iff (rst)
    !vld[ST_OUT] |-> s_axis_tready)
    else $error("input stalled while output register empty");

  a_res_floor: assert property (@(posedge clk) disable iff (rst)
    vld[ST_NORM-1] && !sat[ST_NORM-1] |-> d1_q[D1_N-1] >= 26'd10000)
    else $error("divider resistance below nominal");

  a_norm_msb: assert property (@(posedge clk) disable iff (rst)
    vld[ST_NORM] && !sat[ST_NORM] |-> nm_m[30])
    else $error("log2 mantissa not normalized");

  a_inv_floor: assert property (@(posedge clk) disable iff (rst)
    vld[ST_INV] |-> inv >= ntc_pkg::INV_T0)
    else $error("reciprocal below 1/298");

  a_temp_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ($signed(temp) <= 11'sd1000) && ($signed(temp) >= -11'sd1000))
    else $error("temperature out of range");

endmodule

### tb/ntc_thermistor_temperature_checker.sv
// ----------------------------------------------------------------------------
// ntc_thermistor_temperature_checker
// Watches the ADC code requests and temperature results of the NTC converter,
// predicts each temperature in fixed point and compares in order.
// ----------------------------------------------------------------------------
module ntc_thermistor_temperature_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,
  input  logic        cfg_wr_en,
  input  logic [0:0]  cfg_addr,
  input  logic [13:0] cfg_wdata,
  output int          err_count,
  output int          pending_temps,
  output int          temps_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [ntc_pkg::VREF_W-1:0] vref_mv;
  logic [ntc_pkg::BETA_W-1:0] beta_k;
  logic [15:0]                temp_fifo[$];

  // log2 in Q30 by repeated squaring
  function automatic longint unsigned log2_fixed(input longint unsigned x);
    longint unsigned m, acc;
    int msb;
    if (x == 0) return 0;
    msb = 0;
    while (msb < 62 && (x >> (msb + 1)) != 0) msb++;
    if (msb > 30) return longint'(msb) << 30;
    m   = x << (30 - msb);
    acc = longint'(msb) << 30;
    for (int i = 29; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= (64'd2 << 30)) begin
        m   = m >> 1;
        acc = acc | (64'd1 << i);
      end
    end
    return acc;
  endfunction

  function automatic logic [15:0] temp_of_code(input logic signed [15:0] adc);
    longint code, mv, den, tc, d, res;
    longint unsigned r, l2, ln, b, inv, t;
    code = adc;
    if (code >= longint'(vref_mv)) code = vref_mv;
    if (code < 0) code = 0;
    mv  = (longint'(vref_mv) * code) / 4096;
    den = 5000 - mv;
    if (den <= 0) begin
      res = -1000;
    end else begin
      r   = 64'd50000000 / longint'(den);
      l2  = log2_fixed(r) - log2_fixed(64'd10000);
      ln  = (l2 * 64'd744261118) >> 30;
      b   = (beta_k == 0) ? 64'd1 : 64'(beta_k);
      inv = (ln << 9) / b + ((64'd1 << 39) + 64'd149) / 64'd298;
      t   = (64'd1 << 63) / inv;
      tc  = longint'(t) - (longint'(273) << 24);
      if (tc >= (longint'(100) << 24)) tc = longint'(100) << 24;
      if (tc <= -(longint'(100) << 24)) tc = -(longint'(100) << 24);
      d = tc * 10;
      if (d >= 0) res = longint'(longint'(unsigned'(d)) >>> 24);
      else res = -longint'(64'(-d) >> 24);
    end
    return {5'd0, 11'(res)};
  endfunction

  always @(posedge clk) begin
    logic [15:0] want;
    if (rst) begin
      vref_mv = ntc_pkg::VREF_RST;
      beta_k  = ntc_pkg::BETA_RST;
      temp_fifo.delete();
      err_count  <= 0;
      temps_seen <= 0;
    end else begin
      // result side first: registers never change while busy
      if (m_axis_tvalid && m_axis_tready) begin
        temps_seen <= temps_seen + 1;
        if (temp_fifo.size() == 0) begin
          if (err_count < 10) $display("unexpected temperature %h", m_axis_tdata);
          err_count <= err_count + 1;
        end else begin
          want = temp_fifo.pop_front();
          if (want !== m_axis_tdata) begin
            if (err_count < 10)
              $display("temp mismatch: expected %0d got %0d (raw %h)",
                       $signed(want[10:0]), $signed(m_axis_tdata[10:0]), m_axis_tdata);
            err_count <= err_count + 1;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) temp_fifo.push_back(temp_of_code(s_axis_tdata));
      if (cfg_wr_en) begin
        if (cfg_addr == ntc_pkg::REG_VREF) vref_mv = cfg_wdata[ntc_pkg::VREF_W-1:0];
        else beta_k = cfg_wdata[ntc_pkg::BETA_W-1:0];
      end
    end
    pending_temps <= temp_fifo.size();
  end
endmodule

### tb/ntc_thermistor_temperature_top_tb.sv
// ----------------------------------------------------------------------------
// ntc_thermistor_temperature_top_tb
// Drives ADC codes under several reference and B settings with random
// gaps and output stalls; the checker predicts and compares each result.
// ----------------------------------------------------------------------------
module ntc_thermistor_temperature_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 90;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk, rst;
  logic        s_axis_tvalid, s_axis_tready;
  logic [15:0] s_axis_tdata;   // [15:0] adc_code
  logic        m_axis_tvalid, m_axis_tready;
  logic [15:0] m_axis_tdata;   // [10:0] temp_decidegree, [15:11] zero
  logic        cfg_wr_en;
  logic [0:0]  cfg_addr;
  logic [13:0] cfg_wdata;
  int          err_count, pending_temps, temps_seen;
  int          cycles;
  bit          quiet_mode;
  bit          hold_off;

  ntc_thermistor_temperature_top dut (.*);
  ntc_thermistor_temperature_checker chk (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // run watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // receiver: random stall bursts, long hold-off on request
  initial begin
    m_axis_tready = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off) begin
        m_axis_tready <= 0;
        repeat (300) @(negedge clk);
        hold_off = 0;
      end else if (!quiet_mode && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
      end else begin
        m_axis_tready <= 1;
        repeat ($urandom_range(1, 30)) @(negedge clk);
      end
    end
  end

  task automatic send_code(input logic [15:0] code);
    if (!quiet_mode && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata  <= code;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_pipe();
    s_axis_tvalid <= 0;
    while (pending_temps != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
  endtask

  task automatic write_reg(input ntc_pkg::cfg_reg_t idx, input logic [13:0] val);
    cfg_wr_en <= 1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 0;
    @(negedge clk);
  endtask

  // random code: mostly inside 0..vref, some out of range
  function automatic logic [15:0] pick_code(input int vref);
    case ($urandom_range(0, 9))
      0: return 16'($urandom);
      1: return 16'(vref - 1 + $urandom_range(0, 2));
      2: return 16'($urandom_range(0, 3));
      default: return 16'($urandom_range(0, vref));
    endcase
  endfunction

  initial begin
    int vrefs[6] = '{2500, 1000, 4999, 4095, 4096, 3000};
    int betas[6] = '{3477, 1000, 10000, 16383, 0, 5000};
    logic [15:0] directed[] = '{16'h0000, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001,
                                16'd2499, 16'd2500, 16'd2501, 16'd1250, 16'd600,
                                16'd2000, 16'd2400, 16'd100, 16'h5555, 16'hAAAA};
    rst = 1;
    s_axis_tvalid = 0;
    s_axis_tdata  = 0;
    cfg_wr_en = 0;
    cfg_addr  = ntc_pkg::REG_VREF;
    cfg_wdata = 0;
    quiet_mode = 0;
    hold_off = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed codes at reset settings
    foreach (directed[i]) send_code(directed[i]);
    drain_pipe();

    // random phases over register settings
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(ntc_pkg::REG_VREF, 14'(vrefs[ph]));
      write_reg(ntc_pkg::REG_BETA, 14'(betas[ph]));
      if (ph == 5) quiet_mode = 1;
      for (int k = 0; k < 215; k++) begin
        if (ph == 1 && k == 20) hold_off = 1;
        send_code(k < 4 ? directed[k] : pick_code(vrefs[ph]));
      end
      drain_pipe();
    end

    $display("covered %0d temperatures over 6 reference/B settings plus reset setting",
             temps_seen);
    if (err_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
